[hw/rtl/olm_pkg.sv]
package olm_pkg;

  localparam int MAX_OP_LEN = 4;
  localparam int OP_COUNT   = 46;
  localparam int CHAR_W     = 8;
  localparam int CODE_W     = 6;
  localparam int LEN_W      = 3;
  localparam int WIN_W      = MAX_OP_LEN * CHAR_W;

  // Window bytes packed with the first byte in the low bits.
  typedef logic [WIN_W-1:0] win_t;

  // Input transfer, char0 in the lowest bits, padded to whole bytes.
  typedef struct packed {
    logic [4:0]        pad;
    logic [LEN_W-1:0]  valid_count;
    logic [CHAR_W-1:0] char3;
    logic [CHAR_W-1:0] char2;
    logic [CHAR_W-1:0] char1;
    logic [CHAR_W-1:0] char0;
  } olm_in_t;

  // Output transfer, token_code in the lowest bits.
  typedef struct packed {
    logic [6:0]        pad;
    logic [LEN_W-1:0]  match_len;
    logic [CODE_W-1:0] token_code;
  } olm_out_t;

  localparam int IN_W  = $bits(olm_in_t);
  localparam int OUT_W = $bits(olm_out_t);

  // Operator bytes, byte 0 in the low bits; unused bytes are zero.
  localparam win_t OP_CHARS [OP_COUNT] = '{
    32'h00000028, 32'h00000029, 32'h0000005B, 32'h0000005D,
    32'h0000007B, 32'h0000007D, 32'h0000002C, 32'h0000003A,
    32'h0000002E, 32'h0000002B, 32'h0000002D, 32'h0000002A,
    32'h0000002F, 32'h00000025, 32'h00002B2B, 32'h00002D2D,
    32'h00000021, 32'h0000003D, 32'h00003D3D, 32'h00003D21,
    32'h0000003C, 32'h0000003E, 32'h00003D3C, 32'h00003D3E,
    32'h00002626, 32'h00007C7C, 32'h00000026, 32'h0000007C,
    32'h0000005E, 32'h0000007E, 32'h00003C3C, 32'h00003E3E,
    32'h003C3C3C, 32'h003E3E3E, 32'h00003D2B, 32'h00003D2D,
    32'h00003D2A, 32'h00003D2F, 32'h00003D25, 32'h00003D26,
    32'h00003D7C, 32'h00003D5E, 32'h003D3C3C, 32'h003D3E3E,
    32'h3D3C3C3C, 32'h3D3E3E3E
  };

  localparam logic [LEN_W-1:0] OP_LENS [OP_COUNT] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd1, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4
  };

endpackage

[hw/rtl/olm_stage.sv]
module olm_stage import olm_pkg::*; #(
  parameter int WIDTH = IN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             full;
  logic [WIDTH-1:0] data;

  // Take a new transfer when empty or when the held one leaves in the same cycle.
  assign in_ready  = !full || out_ready;
  assign out_valid = full;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

[hw/rtl/olm_match.sv]
module olm_match import olm_pkg::*; (
  input  olm_in_t  item,
  output olm_out_t result
);

  win_t                    win;
  logic [LEN_W-1:0]        valid_sat;
  logic [OP_COUNT-1:0]     hit;
  logic [CODE_W-1:0]       code_by_len [1:MAX_OP_LEN];

  assign win = {item.char3, item.char2, item.char1, item.char0};
  assign valid_sat = (item.valid_count > LEN_W'(MAX_OP_LEN)) ?
                     LEN_W'(MAX_OP_LEN) : item.valid_count;

  // Compare every operator against the window at once.
  always_comb begin
    for (int k = 0; k < OP_COUNT; k++) begin
      hit[k] = (OP_LENS[k] <= valid_sat);
      for (int i = 0; i < MAX_OP_LEN; i++) begin
        if (LEN_W'(i) < OP_LENS[k] &&
            win[i*CHAR_W +: CHAR_W] != OP_CHARS[k][i*CHAR_W +: CHAR_W]) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // At most one operator of each length can match; merge codes per length.
  always_comb begin
    for (int l = 1; l <= MAX_OP_LEN; l++) begin
      code_by_len[l] = '0;
    end
    for (int k = 0; k < OP_COUNT; k++) begin
      for (int l = 1; l <= MAX_OP_LEN; l++) begin
        if (hit[k] && OP_LENS[k] == LEN_W'(l)) begin
          code_by_len[l] = code_by_len[l] | CODE_W'(k + 1);
        end
      end
    end
  end

  // Longest length wins.
  always_comb begin
    result = '0;
    for (int l = 1; l <= MAX_OP_LEN; l++) begin
      if (code_by_len[l] != '0) begin
        result.token_code = code_by_len[l];
        result.match_len  = LEN_W'(l);
      end
    end
  end

endmodule

[hw/rtl/operator_longest_match.sv]
// Longest-operator recognizer for a lexer front end. Each input transfer
// carries a window of four text bytes and a count of how many are valid
// (counts above four act as four); the block answers with the code (1..46)
// and length of the longest operator that is a prefix of the valid bytes,
// or code 0 and length 0 when none matches. An input register feeds the
// table compare, which loads the result register. One transfer is taken
// every cycle; the only hold-off is back pressure on the output.
module operator_longest_match import olm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // char0[7:0], char1[15:8], char2[23:16], char3[31:24],
  // valid_count[34:32], zero pad[39:35]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // token_code[5:0], match_len[8:6], zero pad[15:9]
  output logic [OUT_W-1:0] m_axis_tdata
);

  logic            mid_valid;
  logic            mid_ready;
  logic [IN_W-1:0] mid_data;
  olm_out_t        match_res;

  olm_stage #(.WIDTH(IN_W)) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  olm_match u_match (
    .item   (olm_in_t'(mid_data)),
    .result (match_res)
  );

  olm_stage #(.WIDTH(OUT_W)) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (match_res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

[hw/rtl/olm_checker.sv]
module olm_checker import olm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  olm_out_t res;
  assign res = olm_out_t'(m_axis_tdata);

  // No code without a length and no length without a code.
  a_code_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((res.token_code == '0) == (res.match_len == '0)))
    else $error("token_code and match_len disagree on a miss");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.token_code <= CODE_W'(OP_COUNT) &&
                       res.match_len <= LEN_W'(MAX_OP_LEN) && res.pad == '0))
    else $error("result out of range");

  // An empty window can never match; if unstalled, it passes the input and output registers.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[34:32] == 3'd0 &&
     m_axis_tready) ##1 m_axis_tready
    |=> (m_axis_tvalid && res.match_len == '0))
    else $error("match reported for empty window");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind operator_longest_match olm_checker u_olm_checker (.*);
